// ===== rtl/tgf_pkg.sv =====
// Package for the grouped FIFO block: sizes, field types, mode and status
// codes, and the control state encoding. No dependencies.
package tgf_pkg;

    localparam int ID_COUNT   = 1024;
    localparam int TEAM_COUNT = 256;
    localparam int CAPACITY   = 1024;

    localparam int ID_W   = $clog2(ID_COUNT);
    localparam int TEAM_W = $clog2(TEAM_COUNT);
    localparam int SLOT_W = $clog2(CAPACITY);

    typedef logic [ID_W-1:0]   t_id;
    typedef logic [TEAM_W-1:0] t_team;
    typedef logic [SLOT_W-1:0] t_slot;

    localparam logic [1:0] MODE_LOAD = 2'd0;
    localparam logic [1:0] MODE_ENQ  = 2'd1;
    localparam logic [1:0] MODE_DEQ  = 2'd2;
    localparam logic [1:0] MODE_NONE = 2'd3;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_LOAD,
        S_ENQ_MAP,
        S_ENQ_SLOT,
        S_ENQ_LINK,
        S_DEQ_RING,
        S_DEQ_TEAM,
        S_DEQ_HEAD,
        S_DEQ_POP,
        S_DONE
    } t_state;

endpackage

// ===== rtl/tgf_if.sv =====
// Handshake channels of the grouped FIFO block: input item and result.
// Depends on tgf_pkg.
interface tgf_in_if import tgf_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    t_id        member_id;
    t_team      team;

    modport source (output valid, output mode, output member_id, output team, input ready);
    modport sink (input valid, input mode, input member_id, input team, output ready);
endinterface

interface tgf_out_if import tgf_pkg::*; ();
    logic       valid;
    logic       ready;
    t_id        out_id;
    logic [1:0] status;

    modport source (output valid, output out_id, output status, input ready);
    modport sink (input valid, input out_id, input status, output ready);
endinterface

// ===== rtl/team_grouped_fifo_unit.sv =====
// Top level of the grouped FIFO (team queue): control sequencer around the
// member map, element, link, team pointer and ring memories.
// Depends on tgf_pkg, tgf_if and tgf_ram.
//
//  channel | dir | beat contents
//  --------+-----+----------------------------
//  i_in    | in  | mode, member_id, team
//  o_out   | out | out_id, status
//
// Steps: a load writes the member map; an enqueue reads the map, takes a slot
// and links it (dropped on a full store); a dequeue reads ring, team pointer
// and head, then pops (stops on an empty queue); unused modes just complete.
// After reset a clearing pass zeroes the member map, with
// i_in.ready low. A result waits in an output register; the next beat is
// taken while it waits, and the block stalls only at the end of that item.
module team_grouped_fifo_unit
    import tgf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    tgf_in_if.sink      i_in,
    tgf_out_if.source   o_out
);

    t_state r_state, n_state;

    t_id          r_clr, n_clr;
    t_id          r_id, n_id;
    t_team        r_team, n_team;
    t_team        r_t, n_t;
    t_slot        r_slot, n_slot;
    t_slot        r_head, n_head;
    t_slot        r_tail, n_tail;
    t_id          r_res_id, n_res_id;
    logic [1:0]   r_res_st, n_res_st;

    logic [TEAM_COUNT-1:0] r_busy, n_busy;
    t_team                 r_front, n_front;
    t_team                 r_back, n_back;
    logic [TEAM_W:0]       r_ring_cnt, n_ring_cnt;
    logic [SLOT_W:0]       r_fresh, n_fresh;
    t_slot                 r_rec_head, n_rec_head;
    logic [SLOT_W:0]       r_rec_cnt, n_rec_cnt;

    logic       r_out_valid;
    t_id        r_out_id;
    logic [1:0] r_out_st;

    logic out_free, in_fire;

    // Memory ports
    logic  map_we;    t_id   map_waddr;  t_team map_wdata;  t_team map_rd;
    logic  mem_we;    t_id   mem_rd;
    logic  lnk_we;    t_slot lnk_waddr;  t_slot lnk_wdata;  t_slot lnk_raddr;  t_slot lnk_rd;
    logic  ht_we;     logic [2*SLOT_W-1:0] ht_wdata;  t_team ht_raddr;
    logic [2*SLOT_W-1:0] ht_rd;
    logic  ring_we;   t_team ring_rd;

    tgf_ram #(.WIDTH(TEAM_W), .DEPTH(ID_COUNT)) u_map (
        .i_clk(i_clk), .i_we(map_we), .i_waddr(map_waddr), .i_wdata(map_wdata),
        .i_raddr(r_id), .o_rdata(map_rd)
    );

    tgf_ram #(.WIDTH(ID_W), .DEPTH(CAPACITY)) u_member (
        .i_clk(i_clk), .i_we(mem_we), .i_waddr(r_slot), .i_wdata(r_id),
        .i_raddr(ht_rd[2*SLOT_W-1:SLOT_W]), .o_rdata(mem_rd)
    );

    tgf_ram #(.WIDTH(SLOT_W), .DEPTH(CAPACITY)) u_link (
        .i_clk(i_clk), .i_we(lnk_we), .i_waddr(lnk_waddr), .i_wdata(lnk_wdata),
        .i_raddr(lnk_raddr), .o_rdata(lnk_rd)
    );

    tgf_ram #(.WIDTH(2*SLOT_W), .DEPTH(TEAM_COUNT)) u_team_ptr (
        .i_clk(i_clk), .i_we(ht_we), .i_waddr(r_t), .i_wdata(ht_wdata),
        .i_raddr(ht_raddr), .o_rdata(ht_rd)
    );

    tgf_ram #(.WIDTH(TEAM_W), .DEPTH(TEAM_COUNT)) u_ring (
        .i_clk(i_clk), .i_we(ring_we), .i_waddr(r_back), .i_wdata(r_t),
        .i_raddr(r_front), .o_rdata(ring_rd)
    );

    assign out_free   = !r_out_valid || o_out.ready;
    assign i_in.ready = (r_state == S_IDLE) || ((r_state == S_DONE) && out_free);
    assign in_fire    = i_in.valid && i_in.ready;

    assign o_out.valid  = r_out_valid;
    assign o_out.out_id = r_out_id;
    assign o_out.status = r_out_st;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr == '1) n_state = S_IDLE;
            end
            S_IDLE, S_DONE: begin
                if (in_fire) begin
                    priority case (i_in.mode)
                        MODE_LOAD: n_state = S_LOAD;
                        MODE_ENQ:  n_state = S_ENQ_MAP;
                        MODE_DEQ:  n_state = S_DEQ_RING;
                        default:   n_state = S_DONE;
                    endcase
                end else if (r_state == S_DONE && out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_LOAD:     n_state = S_DONE;
            S_ENQ_MAP:  n_state = S_ENQ_SLOT;
            S_ENQ_SLOT: begin
                if (r_rec_cnt == '0 && r_fresh >= (SLOT_W+1)'(CAPACITY)) n_state = S_DONE;
                else n_state = S_ENQ_LINK;
            end
            S_ENQ_LINK: n_state = S_DONE;
            S_DEQ_RING: n_state = (r_ring_cnt == '0) ? S_DONE : S_DEQ_TEAM;
            S_DEQ_TEAM: n_state = S_DEQ_HEAD;
            S_DEQ_HEAD: n_state = S_DEQ_POP;
            S_DEQ_POP:  n_state = S_DONE;
            default:    n_state = S_CLEAR;
        endcase
    end

    // Datapath and memory controls
    always_comb begin
        n_clr      = r_clr;
        n_id       = r_id;
        n_team     = r_team;
        n_t        = r_t;
        n_slot     = r_slot;
        n_head     = r_head;
        n_tail     = r_tail;
        n_res_id   = r_res_id;
        n_res_st   = r_res_st;
        n_busy     = r_busy;
        n_front    = r_front;
        n_back     = r_back;
        n_ring_cnt = r_ring_cnt;
        n_fresh    = r_fresh;
        n_rec_head = r_rec_head;
        n_rec_cnt  = r_rec_cnt;

        map_we    = 1'b0;
        map_waddr = r_id;
        map_wdata = r_team;
        mem_we    = 1'b0;
        lnk_we    = 1'b0;
        lnk_waddr = r_head;
        lnk_wdata = r_rec_head;
        lnk_raddr = (r_state == S_DEQ_HEAD) ? ht_rd[2*SLOT_W-1:SLOT_W] : r_rec_head;
        ht_we     = 1'b0;
        ht_wdata  = {r_slot, r_slot};
        ht_raddr  = (r_state == S_ENQ_SLOT) ? map_rd : ring_rd;
        ring_we   = 1'b0;

        if (in_fire) begin
            n_id     = i_in.member_id;
            n_team   = i_in.team;
            n_res_id = '0;
            n_res_st = ST_DONE;
        end

        unique case (r_state)
            S_CLEAR: begin
                map_we    = 1'b1;
                map_waddr = r_clr;
                map_wdata = '0;
                n_clr     = r_clr + 1'b1;
            end
            S_LOAD: begin
                map_we = 1'b1;
            end
            S_ENQ_SLOT: begin
                n_t = map_rd;
                // Recycled slots are taken before fresh ones.
                if (r_rec_cnt != '0) begin
                    n_slot     = r_rec_head;
                    n_rec_head = lnk_rd;
                    n_rec_cnt  = r_rec_cnt - 1'b1;
                end else if (r_fresh < (SLOT_W+1)'(CAPACITY)) begin
                    n_slot  = r_fresh[SLOT_W-1:0];
                    n_fresh = r_fresh + 1'b1;
                end else begin
                    n_res_st = ST_FULL;
                end
            end
            S_ENQ_LINK: begin
                mem_we = 1'b1;
                ht_we  = 1'b1;
                if (!r_busy[r_t]) begin
                    n_busy[r_t] = 1'b1;
                    if (r_ring_cnt < (TEAM_W+1)'(TEAM_COUNT)) begin
                        ring_we    = 1'b1;
                        n_back     = r_back + 1'b1;
                        n_ring_cnt = r_ring_cnt + 1'b1;
                    end
                end else begin
                    ht_wdata  = {ht_rd[2*SLOT_W-1:SLOT_W], r_slot};
                    lnk_we    = 1'b1;
                    lnk_waddr = ht_rd[SLOT_W-1:0];
                    lnk_wdata = r_slot;
                end
            end
            S_DEQ_RING: begin
                if (r_ring_cnt == '0) n_res_st = ST_EMPTY;
            end
            S_DEQ_TEAM: begin
                n_t = ring_rd;
            end
            S_DEQ_HEAD: begin
                n_head = ht_rd[2*SLOT_W-1:SLOT_W];
                n_tail = ht_rd[SLOT_W-1:0];
            end
            S_DEQ_POP: begin
                n_res_id   = mem_rd;
                lnk_we     = 1'b1;
                n_rec_head = r_head;
                n_rec_cnt  = r_rec_cnt + 1'b1;
                if (r_head == r_tail) begin
                    n_busy[r_t] = 1'b0;
                    n_front     = r_front + 1'b1;
                    n_ring_cnt  = r_ring_cnt - 1'b1;
                end else begin
                    ht_we    = 1'b1;
                    ht_wdata = {lnk_rd, r_tail};
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_busy      <= '0;
            r_front     <= '0;
            r_back      <= '0;
            r_ring_cnt  <= '0;
            r_fresh     <= '0;
            r_rec_head  <= '0;
            r_rec_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr      <= n_clr;
            r_busy     <= n_busy;
            r_front    <= n_front;
            r_back     <= n_back;
            r_ring_cnt <= n_ring_cnt;
            r_fresh    <= n_fresh;
            r_rec_head <= n_rec_head;
            r_rec_cnt  <= n_rec_cnt;
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_id     <= n_id;
        r_team   <= n_team;
        r_t      <= n_t;
        r_slot   <= n_slot;
        r_head   <= n_head;
        r_tail   <= n_tail;
        r_res_id <= n_res_id;
        r_res_st <= n_res_st;
        if (r_state == S_DONE && out_free) begin
            r_out_id <= r_res_id;
            r_out_st <= r_res_st;
        end
    end

    a_ring_matches_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_ring_cnt) == $countones(r_busy))
        else $error("ring count differs from number of busy teams");

    a_free_list_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rec_cnt <= r_fresh)
        else $error("free list longer than slots ever handed out");

    a_empty_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DEQ_RING && r_ring_cnt == '0) |=> (r_res_st == ST_EMPTY))
        else $error("dequeue on empty ring not flagged");

endmodule

// ===== rtl/tgf_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module tgf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
